// File: rtl/bsm_pkg.sv
`timescale 1ns / 1ps

package bsm_pkg;

  // Register decode: {address[15:13], address[0]}
  localparam logic [3:0] DEC_BANK_SELECT = 4'b1000;
  localparam logic [3:0] DEC_BANK_DATA   = 4'b1001;
  localparam logic [3:0] DEC_MIRROR      = 4'b1010;
  localparam logic [3:0] DEC_RAM_PROTECT = 4'b1011;
  localparam logic [3:0] DEC_IRQ_COUNT   = 4'b1100;
  localparam logic [3:0] DEC_IRQ_RELOAD  = 4'b1101;
  localparam logic [3:0] DEC_IRQ_DISABLE = 4'b1110;
  localparam logic [3:0] DEC_IRQ_ENABLE  = 4'b1111;

  // Bank data targets, bank_select[2:0]
  localparam logic [2:0] TGT_CHR_PAIR0   = 3'd0;
  localparam logic [2:0] TGT_CHR_PAIR1   = 3'd1;
  localparam logic [2:0] TGT_CHR_SINGLE0 = 3'd2;
  localparam logic [2:0] TGT_CHR_SINGLE1 = 3'd3;
  localparam logic [2:0] TGT_CHR_SINGLE2 = 3'd4;
  localparam logic [2:0] TGT_CHR_SINGLE3 = 3'd5;
  localparam logic [2:0] TGT_PRG_FIRST   = 3'd6;
  localparam logic [2:0] TGT_PRG_SECOND  = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] CFG_PRG_BANK_COUNT = 2'd0;
  localparam logic [1:0] CFG_HAS_CHR_ROM    = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN    = 2'd2;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;

  // bank_select bit positions
  localparam int BSEL_CHR_SWAP = 7;
  localparam int BSEL_PRG_SWAP = 6;

  typedef struct packed {
    logic [8:0] prg_bank_count;
    logic       has_chr_rom;
    logic       four_screen;
  } bsm_cfg_t;

  typedef struct packed {
    logic        command;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  scanline;
    logic        rendering_enabled;
  } bsm_item_t;

  typedef struct packed {
    logic [7:0]      bank_select;
    logic [7:0]      prg_bank_first;
    logic [7:0]      prg_bank_second;
    logic [1:0][7:0] chr_pair_banks;
    logic [3:0][7:0] chr_single_banks;
    logic [7:0]      irq_count;
    logic [7:0]      irq_reload;
    logic            irq_on;
    logic            mirror_state;
  } bsm_state_t;

  typedef struct packed {
    logic [31:0] prg_map;
    logic [31:0] chr_map_low;
    logic [31:0] chr_map_high;
    logic        mirror_horizontal;
    logic        irq_pulse;
  } bsm_result_t;

  // Pattern slot byte: bit 6 set means a RAM page, only bits 2:0 kept
  function automatic logic [7:0] slot_byte(input logic [7:0] b);
    slot_byte = b[6] ? {5'b01000, b[2:0]} : b;
  endfunction

endpackage

// File: rtl/bsm_if.sv
`timescale 1ns / 1ps

interface bsm_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] address;
  logic [7:0]  write_data;
  logic [8:0]  scanline;
  logic        rendering_enabled;

  modport source (output valid, command, address, write_data, scanline,
                  rendering_enabled, input ready);
  modport sink   (input valid, command, address, write_data, scanline,
                  rendering_enabled, output ready);
endinterface

interface bsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] prg_map;
  logic [31:0] chr_map_low;
  logic [31:0] chr_map_high;
  logic        mirror_horizontal;
  logic        irq_pulse;

  modport source (output valid, prg_map, chr_map_low, chr_map_high,
                  mirror_horizontal, irq_pulse, input ready);
  modport sink   (input valid, prg_map, chr_map_low, chr_map_high,
                  mirror_horizontal, irq_pulse, output ready);
endinterface

interface bsm_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/bsm_regs.sv
`timescale 1ns / 1ps

module bsm_regs import bsm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  bsm_item_t  item,
  input  bsm_cfg_t   cfg,
  output bsm_state_t state_nxt,
  output logic       irq_pulse
);

  bsm_state_t state_r;
  logic [3:0] dec;
  logic [2:0] target;
  logic [1:0] single_idx;

  assign dec        = {item.address[15:13], item.address[0]};
  assign target     = state_r.bank_select[2:0];
  assign single_idx = target[1:0] - 2'd2;

  always_comb begin
    state_nxt = state_r;
    irq_pulse = 1'b0;
    if (step) begin
      if (item.command == CMD_TICK) begin
        if (state_r.irq_on && (item.scanline <= LAST_VISIBLE_LINE) &&
            item.rendering_enabled) begin
          if (state_r.irq_count == 8'd0) begin
            state_nxt.irq_count = state_r.irq_reload;
            irq_pulse           = 1'b1;
          end else begin
            state_nxt.irq_count = state_r.irq_count - 8'd1;
          end
        end
      end else begin
        unique case (dec)
          DEC_BANK_SELECT: state_nxt.bank_select = item.write_data;
          DEC_BANK_DATA: begin
            // pattern targets are dropped when the cart has no pattern ROM
            if (cfg.has_chr_rom || target == TGT_PRG_FIRST || target == TGT_PRG_SECOND) begin
              unique case (target)
                TGT_CHR_PAIR0:
                  state_nxt.chr_pair_banks[0] = {item.write_data[7:1], 1'b0};
                TGT_CHR_PAIR1:
                  state_nxt.chr_pair_banks[1] = {item.write_data[7:1], 1'b0};
                TGT_CHR_SINGLE0, TGT_CHR_SINGLE1, TGT_CHR_SINGLE2, TGT_CHR_SINGLE3:
                  state_nxt.chr_single_banks[single_idx] = item.write_data;
                TGT_PRG_FIRST:  state_nxt.prg_bank_first  = item.write_data;
                TGT_PRG_SECOND: state_nxt.prg_bank_second = item.write_data;
                default: ;
              endcase
            end
          end
          DEC_MIRROR: begin
            if (!cfg.four_screen) begin
              state_nxt.mirror_state = item.write_data[0];
            end
          end
          DEC_IRQ_COUNT:   state_nxt.irq_count  = item.write_data;
          DEC_IRQ_RELOAD:  state_nxt.irq_reload = item.write_data;
          DEC_IRQ_DISABLE: state_nxt.irq_on     = 1'b0;
          DEC_IRQ_ENABLE:  state_nxt.irq_on     = 1'b1;
          default: ;  // below 0x8000 and RAM protect
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.bank_select         <= 8'd0;
      state_r.prg_bank_first      <= 8'd0;
      state_r.prg_bank_second     <= 8'd1;
      state_r.chr_pair_banks[0]   <= 8'd0;
      state_r.chr_pair_banks[1]   <= 8'd2;
      state_r.chr_single_banks[0] <= 8'd4;
      state_r.chr_single_banks[1] <= 8'd5;
      state_r.chr_single_banks[2] <= 8'd6;
      state_r.chr_single_banks[3] <= 8'd7;
      state_r.irq_count           <= 8'd0;
      state_r.irq_reload          <= 8'd0;
      state_r.irq_on              <= 1'b0;
      state_r.mirror_state        <= 1'b0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/bsm_map.sv
`timescale 1ns / 1ps

module bsm_map import bsm_pkg::*; (
  input  bsm_state_t  state,
  input  bsm_cfg_t    cfg,
  input  logic        irq_pulse,
  output bsm_result_t result
);

  logic [7:0]  last_bank;
  logic [7:0]  prev_bank;
  logic [7:0]  slot0;
  logic [7:0]  slot2;
  logic [31:0] pair_word;
  logic [31:0] single_word;

  // fixed slots wrap modulo 256
  assign last_bank = cfg.prg_bank_count[7:0] - 8'd1;
  assign prev_bank = cfg.prg_bank_count[7:0] - 8'd2;

  assign slot0 = state.bank_select[BSEL_PRG_SWAP] ? prev_bank : state.prg_bank_first;
  assign slot2 = state.bank_select[BSEL_PRG_SWAP] ? state.prg_bank_first : prev_bank;

  assign pair_word = {slot_byte(state.chr_pair_banks[1] + 8'd1),
                      slot_byte(state.chr_pair_banks[1]),
                      slot_byte(state.chr_pair_banks[0] + 8'd1),
                      slot_byte(state.chr_pair_banks[0])};

  assign single_word = {slot_byte(state.chr_single_banks[3]),
                        slot_byte(state.chr_single_banks[2]),
                        slot_byte(state.chr_single_banks[1]),
                        slot_byte(state.chr_single_banks[0])};

  always_comb begin
    result.prg_map           = {last_bank, slot2, state.prg_bank_second, slot0};
    result.chr_map_low       = state.bank_select[BSEL_CHR_SWAP] ? single_word : pair_word;
    result.chr_map_high      = state.bank_select[BSEL_CHR_SWAP] ? pair_word : single_word;
    result.mirror_horizontal = state.mirror_state;
    result.irq_pulse         = irq_pulse;
  end

endmodule

// File: rtl/bank_switch_mapper_with_scanline_irq.sv
`timescale 1ns / 1ps
// Each item passes through the input register and then the result register.
// Throughput: one item per cycle while the result side takes results; the input register
//   can still take one item while a finished result waits, decoupling the sides by one item.
// Reset (rst_n low, synchronous): mapper registers to power-on banks, IRQ off,
//   vertical mirroring, configuration to 2 program banks with pattern ROM, both stages empty.
module bank_switch_mapper_with_scanline_irq import bsm_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  bsm_in_if.sink   in_ch,
  bsm_out_if.source out_ch,
  bsm_cfg_if.sink  cfg_ch
);

  // configuration; the user must write it only while idle, the block does not enforce this
  bsm_cfg_t    cfg_r;

  // input stage
  logic        in_valid_r;
  bsm_item_t   in_item_r;

  // result stage
  logic        out_valid_r;
  bsm_result_t out_result_r;

  bsm_state_t  state_nxt;
  logic        irq_pulse;
  bsm_result_t result_nxt;
  logic        advance;
  logic        in_fire;

  // the input item moves on whenever the result stage is free or being drained
  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prg_bank_count <= 9'd2;
      cfg_r.has_chr_rom    <= 1'b1;
      cfg_r.four_screen    <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_PRG_BANK_COUNT: cfg_r.prg_bank_count <= cfg_ch.data;
        CFG_HAS_CHR_ROM:    cfg_r.has_chr_rom    <= cfg_ch.data[0];
        CFG_FOUR_SCREEN:    cfg_r.four_screen    <= cfg_ch.data[0];
        default: ;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.command           <= in_ch.command;
      in_item_r.address           <= in_ch.address;
      in_item_r.write_data        <= in_ch.write_data;
      in_item_r.scanline          <= in_ch.scanline;
      in_item_r.rendering_enabled <= in_ch.rendering_enabled;
    end
  end

  // register decode and IRQ counter; state updates when the item advances
  bsm_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_item_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .irq_pulse (irq_pulse)
  );

  // slot mapping taken from the post-update state
  bsm_map u_map (
    .state     (state_nxt),
    .cfg       (cfg_r),
    .irq_pulse (irq_pulse),
    .result    (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ch.ready) begin
      out_valid_r <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.prg_map           = out_result_r.prg_map;
  assign out_ch.chr_map_low       = out_result_r.chr_map_low;
  assign out_ch.chr_map_high      = out_result_r.chr_map_high;
  assign out_ch.mirror_horizontal = out_result_r.mirror_horizontal;
  assign out_ch.irq_pulse         = out_result_r.irq_pulse;

endmodule

// File: test/bank_map_checker.sv
`timescale 1ns / 1ps

// Watches the mapper's channels, tracks the cartridge registers on its own
// and compares every result item against the mapping it predicts.
module bank_map_checker import bsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  bsm_in_if    in_mon,
  bsm_out_if   out_mon,
  bsm_cfg_if   cfg_mon,
  output int   pending,
  output int   fail_count,
  output int   maps_checked,
  output int   irqs_seen
);

  bsm_cfg_t    cart;
  bsm_state_t  regs;
  bsm_result_t expected_maps[$];
  int          errors = 0;
  int          checked = 0;
  int          irqs = 0;

  // bit 6 marks a RAM page; only its low three bits survive
  function automatic logic [7:0] bank_or_page(input logic [7:0] b);
    return b[6] ? (8'h40 | (b & 8'h07)) : b;
  endfunction

  function automatic logic [31:0] window_bytes(input logic [3:0][7:0] banks);
    logic [31:0] w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = bank_or_page(banks[i]);
    return w;
  endfunction

  task automatic cpu_write(input logic [15:0] addr, input logic [7:0] data);
    logic [2:0] target;
    target = regs.bank_select[2:0];
    case ({addr[15:13], addr[0]})
      DEC_BANK_SELECT: regs.bank_select = data;
      DEC_BANK_DATA: begin
        // pattern targets are dead without pattern ROM
        if (cart.has_chr_rom || target > TGT_CHR_SINGLE3) begin
          case (target)
            TGT_CHR_PAIR0:  regs.chr_pair_banks[0] = data & 8'hFE;
            TGT_CHR_PAIR1:  regs.chr_pair_banks[1] = data & 8'hFE;
            TGT_PRG_FIRST:  regs.prg_bank_first = data;
            TGT_PRG_SECOND: regs.prg_bank_second = data;
            default:        regs.chr_single_banks[2'(target - TGT_CHR_SINGLE0)] = data;
          endcase
        end
      end
      DEC_MIRROR:      if (!cart.four_screen) regs.mirror_state = data[0];
      DEC_IRQ_COUNT:   regs.irq_count = data;
      DEC_IRQ_RELOAD:  regs.irq_reload = data;
      DEC_IRQ_DISABLE: regs.irq_on = 1'b0;
      DEC_IRQ_ENABLE:  regs.irq_on = 1'b1;
      default: ;  // below 0x8000, RAM protect
    endcase
  endtask

  task automatic count_scanline(input logic [8:0] line, input logic rend, output logic fired);
    fired = 1'b0;
    if (regs.irq_on && line <= LAST_VISIBLE_LINE && rend) begin
      if (regs.irq_count == 8'd0) begin
        regs.irq_count = regs.irq_reload;
        fired = 1'b1;
      end else begin
        regs.irq_count = regs.irq_count - 8'd1;
      end
    end
  endtask

  function automatic bsm_result_t current_maps(input logic fired);
    logic [8:0]      below;
    logic [7:0]      last_bank;
    logic [7:0]      prev_bank;
    logic [3:0][7:0] pair_win;
    bsm_result_t     r;
    below = cart.prg_bank_count - 9'd1;
    last_bank = below[7:0];
    below = cart.prg_bank_count - 9'd2;
    prev_bank = below[7:0];
    if (regs.bank_select[BSEL_PRG_SWAP])
      r.prg_map = {last_bank, regs.prg_bank_first, regs.prg_bank_second, prev_bank};
    else
      r.prg_map = {last_bank, prev_bank, regs.prg_bank_second, regs.prg_bank_first};
    pair_win[0] = regs.chr_pair_banks[0];
    pair_win[1] = regs.chr_pair_banks[0] + 8'd1;
    pair_win[2] = regs.chr_pair_banks[1];
    pair_win[3] = regs.chr_pair_banks[1] + 8'd1;
    if (regs.bank_select[BSEL_CHR_SWAP]) begin
      r.chr_map_low  = window_bytes(regs.chr_single_banks);
      r.chr_map_high = window_bytes(pair_win);
    end else begin
      r.chr_map_low  = window_bytes(pair_win);
      r.chr_map_high = window_bytes(regs.chr_single_banks);
    end
    r.mirror_horizontal = regs.mirror_state;
    r.irq_pulse = fired;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : watch
    bsm_result_t want;
    logic        fired;
    if (!rst_n) begin
      cart = '{prg_bank_count: 9'd2, has_chr_rom: 1'b1, four_screen: 1'b0};
      regs = '0;
      regs.prg_bank_second = 8'd1;
      regs.chr_pair_banks = {8'd2, 8'd0};
      regs.chr_single_banks = {8'd7, 8'd6, 8'd5, 8'd4};
      expected_maps.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_PRG_BANK_COUNT: cart.prg_bank_count = cfg_mon.data;
          CFG_HAS_CHR_ROM:    cart.has_chr_rom = cfg_mon.data[0];
          CFG_FOUR_SCREEN:    cart.four_screen = cfg_mon.data[0];
          default: ;
        endcase
      end
      // results leave only after passing the input and result registers, so check first
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_maps.size() == 0) begin
          $error("result item with no item outstanding");
          errors++;
        end else begin
          want = expected_maps.pop_front();
          check_field("prg_map", want.prg_map, out_mon.prg_map);
          check_field("chr_map_low", want.chr_map_low, out_mon.chr_map_low);
          check_field("chr_map_high", want.chr_map_high, out_mon.chr_map_high);
          check_field("mirror_horizontal", want.mirror_horizontal,
                      out_mon.mirror_horizontal);
          check_field("irq_pulse", want.irq_pulse, out_mon.irq_pulse);
          if (out_mon.irq_pulse === 1'b1) irqs++;
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        fired = 1'b0;
        if (in_mon.command == CMD_TICK)
          count_scanline(in_mon.scanline, in_mon.rendering_enabled, fired);
        else
          cpu_write(in_mon.address, in_mon.write_data);
        expected_maps.push_back(current_maps(fired));
      end
    end
    pending      <= expected_maps.size();
    fail_count   <= errors;
    maps_checked <= checked;
    irqs_seen    <= irqs;
  end

endmodule

// File: test/bank_switch_mapper_with_scanline_irq_test.sv
`timescale 1ns / 1ps

module bank_switch_mapper_with_scanline_irq_test;
  import bsm_pkg::*;

  localparam int RUN_LIMIT_NS     = 2_000_000;
  localparam int RANDOM_PER_PHASE = 83;
  localparam int SETTLE_CYCLES    = 4;   // two pipeline stages plus margin
  localparam int NUM_CARTS        = 6;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;   // when set, neither side idles

  int items_sent = 0;
  int ticks_sent = 0;
  int cfg_writes = 0;
  int pending;
  int fail_count;
  int maps_checked;
  int irqs_seen;

  bsm_in_if  in_ch ();
  bsm_out_if out_ch ();
  bsm_cfg_if cfg_ch ();

  bank_switch_mapper_with_scanline_irq DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bank_map_checker map_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .pending      (pending),
    .fail_count   (fail_count),
    .maps_checked (maps_checked),
    .irqs_seen    (irqs_seen)
  );

  always #4 clk = ~clk;

  // Result side backpressure: ~32% stall, none during the calm stretch
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("bank_switch_mapper_with_scanline_irq_test failed");
    $finish;
  end

  // Address that decodes to a given register; the undecoded bits are noise
  function automatic logic [15:0] reg_address(input logic [3:0] dec);
    return {dec[3:1], 12'($urandom), dec[0]};
  endfunction

  // CPU write item; tick fields carry junk since the block must ignore them
  function automatic bsm_item_t bus_write(input logic [15:0] a, input logic [7:0] d);
    bsm_item_t it;
    it.command = CMD_WRITE;
    it.address = a;
    it.write_data = d;
    it.scanline = 9'($urandom);
    it.rendering_enabled = 1'($urandom);
    return it;
  endfunction

  function automatic bsm_item_t line_tick(input logic [8:0] line, input logic rend);
    bsm_item_t it;
    it.command = CMD_TICK;
    it.address = 16'($urandom);
    it.write_data = 8'($urandom);
    it.scanline = line;
    it.rendering_enabled = rend;
    return it;
  endfunction

  // Called just after a rising edge. Leaves valid high so back-to-back items
  // never drop it; gaps and drain_results lower it.
  task automatic send_item(input bsm_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid             <= 1'b1;
    in_ch.command           <= it.command;
    in_ch.address           <= it.address;
    in_ch.write_data        <= it.write_data;
    in_ch.scanline          <= it.scanline;
    in_ch.rendering_enabled <= it.rendering_enabled;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
    if (it.command == CMD_TICK) ticks_sent++;
  endtask

  // Hold off the sender until every outstanding result has drained, then let
  // the pipeline go quiet. pending is a registered copy, hence the do-while.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [8:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_writes++;
  endtask

  task automatic load_cartridge(input bsm_cfg_t c);
    write_cfg(CFG_PRG_BANK_COUNT, c.prg_bank_count);
    write_cfg(CFG_HAS_CHR_ROM, {8'd0, c.has_chr_rom});
    write_cfg(CFG_FOUR_SCREEN, {8'd0, c.four_screen});
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly what a game does: select/data pairs, IRQ setup, lots of visible
  // scanline ticks with rendering on. The rest is off-screen ticks, stray
  // low writes and RAM protect pokes.
  task automatic send_random_traffic(input int count);
    int          pick;
    logic [8:0]  line;
    logic [15:0] a;
    logic [7:0]  d;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        line = ($urandom_range(4) != 0) ? 9'($urandom_range(LAST_VISIBLE_LINE))
                                        : 9'($urandom_range(511, 240));
        send_item(line_tick(line, $urandom_range(9) != 0));
      end else if (pick < 60) begin
        send_item(bus_write(reg_address(DEC_BANK_SELECT), 8'($urandom)));
        send_item(bus_write(reg_address(DEC_BANK_DATA), 8'($urandom)));
      end else begin
        d = 8'($urandom);
        if (pick < 70) begin
          a = reg_address(DEC_BANK_DATA);
        end else if (pick < 76) begin
          a = reg_address(DEC_MIRROR);
        end else if (pick < 79) begin
          a = reg_address(DEC_RAM_PROTECT);
        end else if (pick < 89) begin
          // small counts so the IRQ actually fires now and then
          a = reg_address((pick < 85) ? DEC_IRQ_RELOAD : DEC_IRQ_COUNT);
          if ($urandom_range(3) != 0) d = 8'($urandom_range(7));
        end else if (pick < 92) begin
          a = reg_address(DEC_IRQ_DISABLE);
        end else if (pick < 97) begin
          a = reg_address(DEC_IRQ_ENABLE);
        end else begin
          a = {1'b0, 15'($urandom)};
        end
        send_item(bus_write(a, d));
      end
    end
  endtask

  initial begin
    bsm_cfg_t carts [NUM_CARTS];

    in_ch.valid             <= 1'b0;
    in_ch.command           <= CMD_WRITE;
    in_ch.address           <= '0;
    in_ch.write_data        <= '0;
    in_ch.scanline          <= '0;
    in_ch.rendering_enabled <= 1'b0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= CFG_PRG_BANK_COUNT;
    cfg_ch.data             <= '0;

    // Cartridge settings: both ends of the bank count, odd counts, every
    // combination of the two flags across the set, then a couple at random
    carts[0] = '{prg_bank_count: 9'd256, has_chr_rom: 1'b1, four_screen: 1'b0};
    carts[1] = '{prg_bank_count: 9'd2,   has_chr_rom: 1'b0, four_screen: 1'b1};
    carts[2] = '{prg_bank_count: 9'd3,   has_chr_rom: 1'b1, four_screen: 1'b1};
    carts[3] = '{prg_bank_count: 9'd255, has_chr_rom: 1'b0, four_screen: 1'b0};
    for (int i = 4; i < NUM_CARTS; i++)
      carts[i] = '{prg_bank_count: 9'($urandom_range(256, 2)),
                   has_chr_rom: 1'($urandom), four_screen: 1'($urandom)};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at reset configuration
    send_item(line_tick(9'd0, 1'b1));                 // IRQ still off: no count
    send_item(bus_write(16'h7FFF, 8'hFF));            // below the register window
    send_item(bus_write(16'h8000, 8'h00));            // select pair 0
    send_item(bus_write(16'h8001, 8'hFF));            // pair bank drops bit 0, +1 gives FF
    send_item(bus_write(16'h9FFE, 8'h01));            // select pair 1 via a mirror address
    send_item(bus_write(16'h8001, 8'h41));            // pair lands in RAM pages
    send_item(bus_write(16'h8000, 8'h02));
    send_item(bus_write(16'h8001, 8'h47));            // single bank as RAM page 7
    send_item(bus_write(16'h8000, 8'h03));
    send_item(bus_write(16'h9FFF, 8'hFF));            // bit 6 set, upper bits dropped
    send_item(bus_write(16'h8000, 8'h06));
    send_item(bus_write(16'h8001, 8'hFF));            // first program bank
    send_item(bus_write(16'h8000, 8'hC7));            // both swaps, target second bank
    send_item(bus_write(16'h8001, 8'h80));
    send_item(bus_write(16'hA000, 8'h01));            // horizontal mirroring
    send_item(bus_write(16'hA001, 8'h00));            // RAM protect: nothing
    send_item(bus_write(16'hC001, 8'h01));            // latch 1
    send_item(bus_write(16'hC000, 8'h00));            // counter at zero
    send_item(bus_write(16'hFFFF, 8'h00));            // enable
    send_item(line_tick(9'd0, 1'b1));                 // zero count: reload and fire
    send_item(line_tick(LAST_VISIBLE_LINE, 1'b1));    // last visible line decrements
    send_item(line_tick(9'd240, 1'b1));               // off screen
    send_item(line_tick(9'd100, 1'b0));               // rendering off
    send_item(line_tick(9'd5, 1'b1));                 // fires again
    send_item(bus_write(16'hE000, 8'h00));            // disable
    send_item(line_tick(9'd10, 1'b1));                // disabled: nothing
    drain_results();

    // Random phases, one per cartridge setting. Config only goes in once the
    // pipeline has drained; phase 2 runs with no idling on either side.
    for (int p = 0; p < NUM_CARTS; p++) begin
      load_cartridge(carts[p]);
      calm <= (p == 2);
      send_random_traffic(RANDOM_PER_PHASE);
      drain_results();
    end
    calm <= 1'b0;

    $display("sent %0d items (%0d scanline ticks) over %0d cartridge settings, %0d cfg writes",
             items_sent, ticks_sent, NUM_CARTS + 1, cfg_writes);
    $display("checked %0d result items, %0d carried an IRQ pulse", maps_checked, irqs_seen);
    if (fail_count == 0) begin
      $display("bank_switch_mapper_with_scanline_irq_test passed");
    end else begin
      $display("bank_switch_mapper_with_scanline_irq_test failed");
    end
    $finish;
  end

endmodule
